// File: src/multichannel_to_stereo_downmix_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo downmix core
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_TO_STEREO_DOWNMIX_CORE_DEFINES_SVH
`define MULTICHANNEL_TO_STEREO_DOWNMIX_CORE_DEFINES_SVH

// Antecedent and consequent checked on the same clock edge.
`define MTSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked on the clock edge after the antecedent.
`define MTSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mtsd_pkg.sv
// ----------------------------------------------------------------------------
// mtsd_pkg
// Types, constants, coefficient tables and rounding for the stereo downmix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtsd_pkg;

	localparam int LANES                = 8;
	localparam int MIN_CHANNELS         = 3;
	localparam int ROWS                 = 6;
	localparam int DEFAULT_MAX_CHANNELS = 8;
	localparam int SAMPLE_W             = 16;
	localparam int COEF_W               = 14;
	localparam int PROD_W               = 31;
	localparam int SUM_W                = 34;
	localparam int CH_W                 = 4;
	localparam int ROW_W                = 3;
	localparam int Q14_ROUND            = 8192;
	localparam int Q14_SHIFT            = 14;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic        [CH_W-1:0]     chan_t;
	typedef logic        [ROW_W-1:0]    row_t;

	localparam chan_t RESET_CHANNELS = chan_t'(6);

	// Q14 coefficients, indexed by [channel count - 3][lane]. Lanes past the
	// channel count of a row hold zero, so they drop out of the sum.
	localparam coef_t COEF_L [ROWS][LANES] = '{
		'{14'd9598,  14'd6786, 14'd0, 14'd0,    14'd0,    14'd0,    14'd0,    14'd0},
		'{14'd6925,  14'd0,    14'd5997, 14'd3462, 14'd0, 14'd0,    14'd0,    14'd0},
		'{14'd10663, 14'd7540, 14'd0, 14'd9234, 14'd5331, 14'd0,    14'd0,    14'd0},
		'{14'd8668,  14'd6129, 14'd0, 14'd7507, 14'd4335, 14'd6129, 14'd0,    14'd0},
		'{14'd7459,  14'd5275, 14'd0, 14'd6460, 14'd3731, 14'd4568, 14'd5275, 14'd0},
		'{14'd6368,  14'd4502, 14'd0, 14'd5514, 14'd3184, 14'd5514, 14'd3184, 14'd4502}
	};

	localparam coef_t COEF_R [ROWS][LANES] = '{
		'{14'd0, 14'd6786, 14'd9598,  14'd0,    14'd0,    14'd0,    14'd0,    14'd0},
		'{14'd0, 14'd6925, 14'd3462,  14'd5997, 14'd0,    14'd0,    14'd0,    14'd0},
		'{14'd0, 14'd7540, 14'd10663, 14'd5331, 14'd9234, 14'd0,    14'd0,    14'd0},
		'{14'd0, 14'd6129, 14'd8668,  14'd4335, 14'd7507, 14'd6129, 14'd0,    14'd0},
		'{14'd0, 14'd5275, 14'd7459,  14'd3731, 14'd6460, 14'd4568, 14'd5275, 14'd0},
		'{14'd0, 14'd4502, 14'd6368,  14'd3184, 14'd5514, 14'd3184, 14'd5514, 14'd4502}
	};

	// Adds half an LSB, shifts right arithmetically by 14 and saturates to
	// the signed 16-bit range.
	function automatic sample_t round_sat(input sum_t sum);
		sum_t shifted;
		sample_t res;
		shifted = (sum + sum_t'(Q14_ROUND)) >>> Q14_SHIFT;
		if (shifted > sum_t'(32767)) begin
			res = sample_t'(32767);
		end else if (shifted < sum_t'(-32768)) begin
			res = sample_t'(-32768);
		end else begin
			res = shifted[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: src/multichannel_to_stereo_downmix_core.sv
// ----------------------------------------------------------------------------
// multichannel_to_stereo_downmix_core
// Surround-to-stereo downmix of one interleaved frame per clock cycle.
// ----------------------------------------------------------------------------
// How the block is used:
// A frame of eight signed 16-bit channel samples plus a last-frame marker is
// transferred in at a rising edge of clk at which start is high and busy is
// low. The block never stalls its source: busy is held low, so a new frame
// can be transferred in every cycle.
// Each frame yields one stereo pair on left_out, right_out and last_out,
// marked by a one-cycle strobe on done. The pair of a frame passes through
// three register stages before it reaches the ports: input capture,
// sixteen parallel lane products, and the per-side sum with rounding and
// saturation. No stage is ever held, so the throughput is one frame per
// cycle.
// The receiver cannot stall; it must take each pair in the cycle it shows.
// The channel count register is written through channel_count_we and
// channel_count_wdata and should only change while no frame is in flight.
// Counts below three act as three, counts above MAX_CHANNELS act as
// MAX_CHANNELS. Lanes at or above the count do not contribute.
// Reset (arst_n low) empties the pipeline, drops done and restores a count
// of six channels. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_to_stereo_downmix_core_defines.svh"

module multichannel_to_stereo_downmix_core
	import mtsd_pkg::*;
#(
	parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
	input  logic          clk,
	input  logic          arst_n,

	// Configuration write port for the channel count.
	input  logic          channel_count_we,
	input  logic [3:0]    channel_count_wdata,

	// Frame input.
	input  logic          start,
	output logic          busy,
	input  sample_t       sample_0,
	input  sample_t       sample_1,
	input  sample_t       sample_2,
	input  sample_t       sample_3,
	input  sample_t       sample_4,
	input  sample_t       sample_5,
	input  sample_t       sample_6,
	input  sample_t       sample_7,
	input  logic          frame_last,

	// Stereo result.
	output logic          done,
	output sample_t       left_out,
	output sample_t       right_out,
	output logic          last_out
);

	// Upper clamp of the channel count, taken from the parameter.
	localparam chan_t MAX_CH = chan_t'(MAX_CHANNELS);
	localparam chan_t MIN_CH = chan_t'(MIN_CHANNELS);

	// The block takes a frame in every cycle and so never pushes back.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Channel count register.
	chan_t channel_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RESET_CHANNELS;
		end else if (channel_count_we) begin
			channel_count_q <= channel_count_wdata;
		end
	end

	// The count is clamped into the supported range and turned into a
	// coefficient row index. Because each row holds zeros past its channel
	// count, the row choice alone masks off the unused lanes.
	chan_t ch_eff;
	chan_t row_wide;
	row_t  row_sel;

	always_comb begin
		if (channel_count_q < MIN_CH) begin
			ch_eff = MIN_CH;
		end else if (channel_count_q > MAX_CH) begin
			ch_eff = MAX_CH;
		end else begin
			ch_eff = channel_count_q;
		end
		row_wide = ch_eff - MIN_CH;
		row_sel  = row_wide[ROW_W-1:0];
	end

	// Stage 1: capture the frame and its coefficient row.
	logic    valid_s1;
	sample_t sample_s1 [LANES];
	logic    last_s1;
	row_t    row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1[0] <= sample_0;
			sample_s1[1] <= sample_1;
			sample_s1[2] <= sample_2;
			sample_s1[3] <= sample_3;
			sample_s1[4] <= sample_4;
			sample_s1[5] <= sample_5;
			sample_s1[6] <= sample_6;
			sample_s1[7] <= sample_7;
			last_s1      <= frame_last;
			row_s1       <= row_sel;
		end
	end

	// Stage 2: one left and one right product for each lane, all in
	// parallel. Coefficients are positive, so they get a zero sign bit.
	prod_t prod_l [LANES];
	prod_t prod_r [LANES];

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			prod_l[j] = prod_t'(sample_s1[j]) * prod_t'($signed({1'b0, COEF_L[row_s1][j]}));
			prod_r[j] = prod_t'(sample_s1[j]) * prod_t'($signed({1'b0, COEF_R[row_s1][j]}));
		end
	end

	logic  valid_s2;
	prod_t prod_l_s2 [LANES];
	prod_t prod_r_s2 [LANES];
	logic  last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_l_s2 <= prod_l;
			prod_r_s2 <= prod_r;
			last_s2   <= last_s1;
		end
	end

	// Stage 3: exact sum per side, then rounding and saturation into the
	// result register. The sum width covers eight full-scale products.
	sum_t sum_l;
	sum_t sum_r;

	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int j = 0; j < LANES; j++) begin
			sum_l = sum_l + sum_t'(prod_l_s2[j]);
			sum_r = sum_r + sum_t'(prod_r_s2[j]);
		end
	end

	logic    done_q;
	sample_t left_q;
	sample_t right_q;
	logic    last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			left_q  <= round_sat(sum_l);
			right_q <= round_sat(sum_r);
			last_q  <= last_s2;
		end
	end

	assign done      = done_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign last_out  = last_q;

	// Every accepted frame produces its strobe on done after passing the pipeline.
	`MTSD_ASSERT_SAME(a_done_follows_accept, accept, ##3 done, "accepted frame lost its result")

	// A strobe only ever answers an accepted frame.
	`MTSD_ASSERT_SAME(a_done_has_frame, done, $past(accept, 3), "result strobe without a frame")

	// The last-frame marker travels with its own frame.
	`MTSD_ASSERT_SAME(a_last_aligned, done, last_out == $past(frame_last, 3),
		"last-frame marker out of step with its frame")

	// A silent frame downmixes to silence whatever the channel count.
	`MTSD_ASSERT_NEXT(a_silence_in_silence_out,
		accept && sample_0 == 16'sd0 && sample_1 == 16'sd0 && sample_2 == 16'sd0 &&
		sample_3 == 16'sd0 && sample_4 == 16'sd0 && sample_5 == 16'sd0 &&
		sample_6 == 16'sd0 && sample_7 == 16'sd0,
		##2 (left_out == 16'sd0 && right_out == 16'sd0),
		"silent frame gave a nonzero result")

endmodule
